FILE: hdl/bgs_pkg.sv
// Package for the bilinear grid sampler: widths, codes, register indexes,
// the configuration struct and the structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package bgs_pkg;

    // Field widths.
    localparam int CELLS_W   = 7;
    localparam int SPACING_W = 31;
    localparam int WORD_W    = 32;
    localparam int INDEX_W   = 12;
    localparam int FRAC_W    = 16;
    // Period (n - 1) * h and divider widths.
    localparam int LEN_W     = CELLS_W + SPACING_W;
    localparam int NUM_W     = LEN_W + FRAC_W;
    // Clamped grid coordinate, Q7.16.
    localparam int U_W       = CELLS_W + FRAC_W;
    // Width of a computed cell address before it is fitted to the store.
    localparam int ACALC_W   = 2 * CELLS_W + 1;

    // Clamp limits in Q7.16.
    localparam logic [U_W-1:0] LO_CLAMP  = U_W'(655);
    localparam logic [U_W-1:0] HI_MARGIN = U_W'(66191);

    // Default store size.
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Input word codes.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SPACING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE    = 3'd5;

    // Blend selections.
    localparam logic [1:0] BLEND_TOP = 2'd0;
    localparam logic [1:0] BLEND_BOT = 2'd1;
    localparam logic [1:0] BLEND_OUT = 2'd2;

    typedef struct packed {
        logic [CELLS_W-1:0]        cells_across;
        logic [CELLS_W-1:0]        cells_down;
        logic [SPACING_W-1:0]      cell_spacing;
        logic signed [WORD_W-1:0]  origin_x;
        logic signed [WORD_W-1:0]  origin_z;
        logic                      wrap_mode;
    } t_cfg;

    typedef struct packed {
        logic       wr_en;
        logic       load;
        logic       prep;
        logic       mod_go;
        logic       div_go;
        logic       take_rem;
        logic       take_coord;
        logic       rd_issue;
        logic       rd_latch;
        logic       mul;
        logic       add;
        logic       out_load;
        logic       axis_z;
        logic [1:0] k;
        logic [1:0] bsel;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic wrap;
    } t_status;

endpackage

FILE: hdl/bgs_if.sv
// Stream interfaces of the bilinear grid sampler: the input word channel
// and the result channel. Depends on nothing.
`timescale 1ns / 1ps

interface bgs_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [11:0]        cell_index;
    logic signed [31:0] cell_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;

    modport source (output valid, cmd, cell_index, cell_value, pos_x, pos_z, input ready);
    modport sink   (input valid, cmd, cell_index, cell_value, pos_x, pos_z, output ready);
endinterface

interface bgs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sampled_value;

    modport source (output valid, sampled_value, input ready);
    modport sink   (input valid, sampled_value, output ready);
endinterface

FILE: hdl/bgs_divider.sv
// Radix-2 restoring divider shared by all divisions of a sample.
// Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bgs_pkg::NUM_W-1:0]  i_num,
    input  logic [bgs_pkg::LEN_W-1:0]  i_den,
    output logic                       o_busy,
    output logic [bgs_pkg::NUM_W-1:0]  o_quo,
    output logic [bgs_pkg::LEN_W-1:0]  o_rem
);
    import bgs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [LEN_W:0]   trial;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign trial = {r_rem, r_num[NUM_W-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // One quotient bit per cycle; quotient bits shift in behind the dividend.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!trial[LEN_W]) begin
                r_rem <= trial[LEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[LEN_W-2:0], r_num[NUM_W-1]};
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

FILE: hdl/bgs_datapath.sv
// Datapath of the bilinear grid sampler: grid store, coordinate math,
// divider, blend multiplier and result register. Depends on bgs_pkg and
// bgs_divider.
`timescale 1ns / 1ps

module bgs_datapath #(
    parameter int MAX_WIDTH  = bgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bgs_pkg::t_cfg              i_cfg,
    input  bgs_pkg::t_cmd              i_cmd,
    output bgs_pkg::t_status           o_status,
    input  logic [bgs_pkg::INDEX_W-1:0] i_cell_index,
    input  logic signed [31:0]         i_cell_value,
    input  logic signed [31:0]         i_pos_x,
    input  logic signed [31:0]         i_pos_z,
    output logic signed [31:0]         o_sampled_value
);
    import bgs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WEW   = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int REW   = (AW > ACALC_W) ? AW : ACALC_W;

    function automatic logic [CELLS_W-1:0] sat_cells(logic [CELLS_W-1:0] v, int maxv);
        if (v < CELLS_W'(2)) return CELLS_W'(2);
        if (int'(v) > maxv) return CELLS_W'(maxv);
        return v;
    endfunction

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic signed [31:0] r_px, r_pz;
    logic [LEN_W-1:0]   r_mag;
    logic               r_neg;
    logic [LEN_W-1:0]   r_len;
    logic [U_W-1:0]     r_ux, r_uz;
    logic signed [31:0] r_cell [4];
    logic signed [49:0] r_prod;
    logic signed [31:0] r_top, r_bot, r_res, r_out;

    logic [CELLS_W-1:0]   nx, ny, n_axis;
    logic [SPACING_W-1:0] h;
    logic signed [32:0]   d;
    logic [32:0]          d_abs;
    logic [LEN_W-1:0]     len_c;
    logic [NUM_W-1:0]     div_num, quo;
    logic [LEN_W-1:0]     div_den, rem;
    logic                 div_busy;
    logic [U_W-1:0]       hi, lo, u_c;
    logic [ACALC_W-1:0]   base, off, addr_c;
    logic [REW-1:0]       raddr_ext;
    logic [WEW-1:0]       waddr_ext;
    logic                 idx_ok;
    logic signed [31:0]   ba, bb;
    logic [FRAC_W-1:0]    bc;
    logic signed [32:0]   diff;
    logic signed [16:0]   cs;

    // Effective grid size and spacing.
    assign nx     = sat_cells(i_cfg.cells_across, MAX_WIDTH);
    assign ny     = sat_cells(i_cfg.cells_down, MAX_HEIGHT);
    assign h      = (i_cfg.cell_spacing == '0) ? SPACING_W'(1) : i_cfg.cell_spacing;
    assign n_axis = i_cmd.axis_z ? ny : nx;

    // Offset from the grid corner and the period along the current axis.
    always_comb begin
        if (i_cmd.axis_z) begin
            d = {r_pz[31], r_pz} - {i_cfg.origin_z[31], i_cfg.origin_z};
        end else begin
            d = {r_px[31], r_px} - {i_cfg.origin_x[31], i_cfg.origin_x};
        end
        d_abs = d[32] ? 33'(-d) : 33'(d);
        len_c = LEN_W'(n_axis - CELLS_W'(1)) * LEN_W'(h);
    end

    // Divider operands: magnitude by period, then scaled magnitude by spacing.
    assign div_num = i_cmd.div_go ? {r_mag, FRAC_W'(0)} : NUM_W'(r_mag);
    assign div_den = i_cmd.div_go ? LEN_W'(h) : r_len;

    bgs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mod_go | i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (quo),
        .o_rem   (rem)
    );

    // Clamp of the quotient into the grid.
    always_comb begin
        hi = {n_axis, FRAC_W'(0)} - HI_MARGIN;
        lo = i_cfg.wrap_mode ? U_W'(0) : LO_CLAMP;
        if (r_neg) begin
            u_c = lo;
        end else if (quo > NUM_W'(hi)) begin
            u_c = hi;
        end else if (quo < NUM_W'(lo)) begin
            u_c = lo;
        end else begin
            u_c = quo[U_W-1:0];
        end
    end

    // Coordinate registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pos_x;
            r_pz <= i_pos_z;
        end
        if (i_cmd.prep) begin
            r_mag <= LEN_W'(d_abs);
            r_neg <= d[32];
            r_len <= len_c;
        end else if (i_cmd.take_rem) begin
            r_mag <= (r_neg && rem != '0) ? r_len - rem : rem;
            r_neg <= 1'b0;
        end
        if (i_cmd.take_coord) begin
            if (i_cmd.axis_z) begin
                r_uz <= u_c;
            end else begin
                r_ux <= u_c;
            end
        end
    end

    // Address of the cell chosen by the read counter.
    always_comb begin
        base = ACALC_W'(r_uz[U_W-1:FRAC_W]) * ACALC_W'(nx)
             + ACALC_W'(r_ux[U_W-1:FRAC_W]);
        case (i_cmd.k)
            2'd0:    off = '0;
            2'd1:    off = ACALC_W'(1);
            2'd2:    off = ACALC_W'(nx);
            default: off = ACALC_W'(nx) + ACALC_W'(1);
        endcase
        addr_c    = base + off;
        raddr_ext = REW'(addr_c);
        waddr_ext = WEW'(i_cell_index);
        idx_ok    = int'(i_cell_index) < DEPTH;
    end

    // Grid store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && idx_ok) begin
            r_mem[waddr_ext[AW-1:0]] <= i_cell_value;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[raddr_ext[AW-1:0]];
        end
    end

    // Blend operands: a + ((b - a) * c) >>> 16.
    always_comb begin
        case (i_cmd.bsel)
            BLEND_TOP: begin
                ba = r_cell[0];
                bb = r_cell[1];
                bc = r_ux[FRAC_W-1:0];
            end
            BLEND_BOT: begin
                ba = r_cell[2];
                bb = r_cell[3];
                bc = r_ux[FRAC_W-1:0];
            end
            default: begin
                ba = r_top;
                bb = r_bot;
                bc = r_uz[FRAC_W-1:0];
            end
        endcase
        diff = {bb[31], bb} - {ba[31], ba};
        cs   = {1'b0, bc};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_latch) begin
            r_cell[i_cmd.k] <= r_rd_data;
        end
        if (i_cmd.mul) begin
            r_prod <= diff * cs;
        end
        if (i_cmd.add) begin
            case (i_cmd.bsel)
                BLEND_TOP: r_top <= ba + r_prod[47:16];
                BLEND_BOT: r_bot <= ba + r_prod[47:16];
                default:   r_res <= ba + r_prod[47:16];
            endcase
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_status.div_busy = div_busy;
    assign o_status.wrap     = i_cfg.wrap_mode;
    assign o_sampled_value   = r_out;

endmodule

FILE: hdl/bgs_ctrl.sv
// Controller of the bilinear grid sampler: sequences coordinate divisions,
// the four cell reads and the three blends. Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bgs_pkg::t_cmd    o_cmd,
    input  bgs_pkg::t_status i_status
);
    import bgs_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_PREP     = 13'b0000000000010,
        S_MOD_GO   = 13'b0000000000100,
        S_MOD_WAIT = 13'b0000000001000,
        S_REM      = 13'b0000000010000,
        S_DIV_GO   = 13'b0000000100000,
        S_DIV_WAIT = 13'b0000001000000,
        S_COORD    = 13'b0000010000000,
        S_READ     = 13'b0000100000000,
        S_LATCH    = 13'b0001000000000,
        S_MUL      = 13'b0010000000000,
        S_ADD      = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_axis, n_axis;
    logic [1:0] r_k, n_k;
    logic [1:0] r_bsel, n_bsel;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_k         = r_k;
        n_bsel      = r_bsel;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        o_cmd.axis_z = r_axis;
        o_cmd.k      = r_k;
        o_cmd.bsel   = r_bsel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_SAMPLE) begin
                        o_cmd.load = 1'b1;
                        n_axis     = 1'b0;
                        n_state    = S_PREP;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.wrap ? S_MOD_GO : S_DIV_GO;
            end
            S_MOD_GO: begin
                o_cmd.mod_go = 1'b1;
                n_state      = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                if (!i_status.div_busy) n_state = S_REM;
            end
            S_REM: begin
                o_cmd.take_rem = 1'b1;
                n_state        = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_status.div_busy) n_state = S_COORD;
            end
            S_COORD: begin
                o_cmd.take_coord = 1'b1;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = S_PREP;
                end else begin
                    n_k     = 2'd0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.rd_latch = 1'b1;
                n_k            = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_bsel  = BLEND_TOP;
                    n_state = S_MUL;
                end else begin
                    n_state = S_READ;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_bsel == BLEND_OUT) begin
                    n_state = S_DONE;
                end else begin
                    n_bsel  = r_bsel + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_k         <= '0;
            r_bsel      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_k         <= n_k;
            r_bsel      <= n_bsel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/bilinear_grid_sampler.sv
// Bilinear grid sampler top level: configuration registers, controller
// and datapath. Depends on bgs_pkg, bgs_if, bgs_ctrl and bgs_datapath.
`timescale 1ns / 1ps

// A write word stores one cell and gives no result. A sample word runs
// from acceptance to a result in the output register as follows: each
// axis needs one division by the spacing, and in periodic mode one more
// by the period, all on one shared divider that retires one quotient bit
// per cycle of a 54-bit quotient; then come four grid reads on the single
// store port and three blends on one multiplier. The next word is taken
// as soon as the previous sample has moved into the output register, even
// while that result still waits. The grid store has no reset: cells must
// be written before any sample reads them.
module bilinear_grid_sampler #(
    parameter int MAX_WIDTH  = bgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bgs_in_if.sink                          i_in,
    bgs_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [bgs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bgs_pkg::WORD_W-1:0]      i_cfg_data
);
    import bgs_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells_across <= CELLS_W'(2);
            r_cfg.cells_down   <= CELLS_W'(2);
            r_cfg.cell_spacing <= SPACING_W'(65536);
            r_cfg.origin_x     <= '0;
            r_cfg.origin_z     <= '0;
            r_cfg.wrap_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CELLS_ACROSS: r_cfg.cells_across <= i_cfg_data[CELLS_W-1:0];
                REG_CELLS_DOWN:   r_cfg.cells_down   <= i_cfg_data[CELLS_W-1:0];
                REG_CELL_SPACING: r_cfg.cell_spacing <= i_cfg_data[SPACING_W-1:0];
                REG_ORIGIN_X:     r_cfg.origin_x     <= i_cfg_data;
                REG_ORIGIN_Z:     r_cfg.origin_z     <= i_cfg_data;
                REG_WRAP_MODE:    r_cfg.wrap_mode    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    bgs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    bgs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cell_index    (i_in.cell_index),
        .i_cell_value    (i_in.cell_value),
        .i_pos_x         (i_in.pos_x),
        .i_pos_z         (i_in.pos_z),
        .o_sampled_value (o_out.sampled_value)
    );

endmodule

FILE: hdl/bgs_checker.sv
// Port-level checks for the bilinear grid sampler, bound to the top level.
// Depends on bgs_pkg and bilinear_grid_sampler.
`timescale 1ns / 1ps

module bgs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_cmd,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);
    import bgs_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    // An accepted sample word closes the input.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_cmd == CMD_SAMPLE |=> !i_in_ready)
        else $error("input open right after a sample word");

    // A cell write leaves the input open.
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_cmd == CMD_WRITE |=> i_in_ready)
        else $error("input closed after a write word");

    // A result only appears at the end of a sample computation.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while the input was idle");

endmodule

bind bilinear_grid_sampler bgs_checker u_bgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.sampled_value)
);

FILE: sim/tb.sv
// Testbench for the bilinear grid sampler: random and directed words with a
// built-in predictor and an in-order result check.
// Depends on bgs_pkg, bgs_if and bilinear_grid_sampler.
`timescale 1ns / 1ps

module tb;
    import bgs_pkg::*;

    typedef struct {
        logic               cmd;
        logic [11:0]        cell_index;
        logic signed [31:0] cell_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
    } grid_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [WORD_W-1:0] i_cfg_data = '0;

    bgs_in_if  in_ch ();
    bgs_out_if out_ch ();

    bilinear_grid_sampler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Words waiting to be sent and samples waiting for their result.
    grid_word_t         word_queue[$];
    logic signed [31:0] sample_queue[$];

    // Shadow of the grid and of the registers.
    logic signed [31:0] grid_shadow [0:4095];
    int unsigned  sh_nx = 2;
    int unsigned  sh_ny = 2;
    longint       sh_spacing = 65536;
    longint       sh_org_x = 0;
    longint       sh_org_z = 0;
    logic         sh_wrap = 1'b0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  fail_count = 0;
    logic took = 1'b0;
    logic want_hold = 1'b0;
    logic hold_used = 1'b0;
    int  hold_left = 0;

    always #6 i_clk = ~i_clk;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    // Clamped grid coordinate in Q7.16 along one axis.
    function automatic longint grid_coord(longint p, longint org, int unsigned n);
        longint d, lo, hi, period, u;
        d = p - org;
        lo = 655;
        hi = longint'(n) * 65536 - 66191;
        if (sh_wrap) begin
            period = longint'(n - 1) * sh_spacing;
            d = d - floor_div(d, period) * period;
            lo = 0;
        end
        u = floor_div(d * 65536, sh_spacing);
        if (u < lo) u = lo;
        if (u > hi) u = hi;
        return u;
    endfunction

    function automatic longint lerp_q16(longint a, longint b, longint c);
        return ((65536 - c) * a + c * b) >>> 16;
    endfunction

    function automatic logic signed [31:0] bilinear_value(longint px, longint pz);
        longint ux, uz, cx, cz, top, bot;
        int unsigned r0, r1;
        ux = grid_coord(px, sh_org_x, sh_nx);
        uz = grid_coord(pz, sh_org_z, sh_ny);
        cx = ux & 16'hFFFF;
        cz = uz & 16'hFFFF;
        r0 = int'(uz >>> 16) * sh_nx + int'(ux >>> 16);
        r1 = r0 + sh_nx;
        top = lerp_q16(grid_shadow[r0], grid_shadow[r0 + 1], cx);
        bot = lerp_q16(grid_shadow[r1], grid_shadow[r1 + 1], cx);
        return 32'(lerp_q16(top, bot, cz));
    endfunction

    // Input side: record accepted words and predict sample results.
    always @(posedge i_clk) begin
        took <= in_ch.valid && in_ch.ready;
        if (in_ch.valid && in_ch.ready) begin
            if (in_ch.cmd == CMD_WRITE)
                grid_shadow[in_ch.cell_index] = in_ch.cell_value;
            else
                sample_queue = {sample_queue, bilinear_value(in_ch.pos_x, in_ch.pos_z)};
        end
    end

    // Word driver, fed from the queue.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || took) begin
            if (word_queue.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
                in_ch.valid <= 1'b0;
            end else begin
                grid_word_t w;
                w = word_queue.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.cmd        <= w.cmd;
                in_ch.cell_index <= w.cell_index;
                in_ch.cell_value <= w.cell_value;
                in_ch.pos_x      <= w.pos_x;
                in_ch.pos_z      <= w.pos_z;
            end
        end
    end

    // Result receiver with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (want_hold && !hold_used) begin
            hold_used = 1'b1;
            hold_left = 1500;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result check against the oldest prediction.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            if (sample_queue.size() == 0) begin
                $error("unexpected result sampled_value=%0d", out_ch.sampled_value);
                fail_count++;
            end else begin
                logic signed [31:0] want;
                want = sample_queue.pop_front();
                if (out_ch.sampled_value !== want) begin
                    $error("sampled_value expected %0d actual %0d", want,
                           out_ch.sampled_value);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (word_queue.size() != 0 || sample_queue.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    function automatic int unsigned fit_cells(logic [6:0] v);
        if (v < 2) return 2;
        if (v > 64) return 64;
        return v;
    endfunction

    function automatic logic signed [31:0] rand_cell();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 131072)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // Idle the block, program every register and reload the used grid area.
    task automatic setup_phase(logic [6:0] nx, logic [6:0] ny, logic [30:0] h,
                               logic [31:0] ox, logic [31:0] oz, logic wrap);
        grid_word_t w;
        wait_idle();
        write_reg(REG_CELLS_ACROSS, 32'(nx));
        write_reg(REG_CELLS_DOWN, 32'(ny));
        write_reg(REG_CELL_SPACING, 32'(h));
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_WRAP_MODE, 32'(wrap));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sh_nx = fit_cells(nx);
        sh_ny = fit_cells(ny);
        sh_spacing = (h == 0) ? 1 : longint'(h);
        sh_org_x = $signed(ox);
        sh_org_z = $signed(oz);
        sh_wrap = wrap;
        for (int k = 0; k < sh_nx * sh_ny; k++) begin
            w = '{CMD_WRITE, 12'(k), rand_cell(), $urandom, $urandom};
            word_queue = {word_queue, w};
        end
    endtask

    function automatic logic signed [31:0] rand_pos(longint org, int unsigned n);
        longint off;
        if ($urandom_range(0, 3) == 0) return $urandom;
        off = longint'($urandom_range(0, n)) * sh_spacing
            + ((longint'($urandom_range(0, 65535)) * sh_spacing) >>> 16)
            - sh_spacing / 2;
        return 32'(org + off);
    endfunction

    task automatic queue_sample(logic signed [31:0] px, logic signed [31:0] pz);
        grid_word_t w;
        w = '{CMD_SAMPLE, 12'($urandom), $urandom, px, pz};
        word_queue = {word_queue, w};
    endtask

    // Random mix: mostly samples inside or near the grid, some stray writes.
    task automatic random_words(int count);
        grid_word_t w;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                w = '{CMD_WRITE, 12'($urandom_range(0, sh_nx * sh_ny - 1)), rand_cell(),
                      $urandom, $urandom};
                word_queue = {word_queue, w};
            end else begin
                queue_sample(rand_pos(sh_org_x, sh_nx), rand_pos(sh_org_z, sh_ny));
            end
        end
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_WRITE;
        in_ch.cell_index = '0;
        in_ch.cell_value = '0;
        in_ch.pos_x      = '0;
        in_ch.pos_z      = '0;
        out_ch.ready     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: default grid with extreme cells and positions.
        send_idle_pct = 36;
        recv_idle_pct = 46;
        setup_phase(7'd2, 7'd2, 31'd65536, 32'd0, 32'd0, 1'b0);
        word_queue.delete();
        word_queue = {word_queue, grid_word_t'{CMD_WRITE, 12'd0, 32'sh7FFFFFFF, 32'sd0, 32'sd0}};
        word_queue = {word_queue, grid_word_t'{CMD_WRITE, 12'd1, 32'sh80000000, 32'sd0, 32'sd0}};
        word_queue = {word_queue, grid_word_t'{CMD_WRITE, 12'd2, 32'sh80000000, 32'sd0, 32'sd0}};
        word_queue = {word_queue, grid_word_t'{CMD_WRITE, 12'd3, 32'sh7FFFFFFF, 32'sd0, 32'sd0}};
        word_queue = {word_queue, grid_word_t'{CMD_WRITE, 12'hFFF, 32'sh12345678, 32'sd0, 32'sd0}};
        queue_sample(32'sd0, 32'sd0);
        queue_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        queue_sample(32'sh80000000, 32'sh80000000);
        queue_sample(32'sd32768, 32'sd32768);
        queue_sample(32'sd65535, 32'sd1);
        queue_sample(-32'sd1, 32'sd65536);
        queue_sample(32'sh7FFFFFFF, 32'sh80000000);

        // Periodic mode, widest grid, smallest spacing, extreme origins.
        setup_phase(7'd64, 7'd2, 31'd1, 32'h80000000, 32'h7FFFFFFF, 1'b1);
        random_words(40);
        // Sizes below and above range, zero spacing.
        setup_phase(7'd0, 7'd127, 31'd0, 32'd0, 32'd0, 1'b0);
        random_words(40);

        send_idle_pct = 46;
        recv_idle_pct = 36;
        setup_phase(7'd127, 7'd1, 31'h7FFFFFFF, $urandom, $urandom, 1'b1);
        random_words(40);
        for (int p = 0; p < 6; p++) begin
            if (p == 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            setup_phase(7'($urandom_range(2, 5)), 7'($urandom_range(2, 5)),
                        (p % 2) ? 31'($urandom) : 31'($urandom_range(1, 1 << 20)),
                        $urandom, $urandom, 1'(p));
            random_words(10);
            if (p == 1) want_hold = 1'b1;
        end

        wait_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #15ms;
        $display("status: fail");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/bgs_pkg.sv
hdl/bgs_if.sv
hdl/bgs_divider.sv
hdl/bgs_datapath.sv
hdl/bgs_ctrl.sv
hdl/bilinear_grid_sampler.sv
hdl/bgs_checker.sv
sim/tb.sv
